// ===== src/cesr_pkg.sv =====
// Shared constants and types for the channel event share reporter.
package cesr_pkg;

  localparam int Channels     = 5;
  localparam int CountWidth   = 16;
  localparam int FieldWidth   = 16;
  localparam int FracBits     = 16;
  localparam int ShareWidth   = FracBits + 1;
  localparam int LevelWidth   = 5;
  localparam int ChIdxWidth   = $clog2(Channels);
  localparam int ChCntWidth   = $clog2(Channels + 1);
  localparam int StepWidth    = $clog2(ShareWidth);

  localparam logic [ShareWidth-1:0] ThresholdReset = ShareWidth'(3277);
  localparam logic [CountWidth-1:0] CountMax       = '1;

  typedef logic [CountWidth-1:0] count_t;
  typedef logic [ShareWidth-1:0] share_t;
  typedef logic [FieldWidth-1:0] field_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_COMPARE,
    ST_REPORT,
    ST_FINISH
  } state_t;

endpackage

// ===== src/cesr_in_if.sv =====
// Sample channel: valid/ready handshake carrying the channel levels.
interface cesr_in_if;
  logic                             valid;
  logic                             ready;
  logic [cesr_pkg::LevelWidth-1:0]  channel_levels;

  modport source (output valid, output channel_levels, input ready);
  modport sink   (input valid, input channel_levels, output ready);
endinterface

// ===== src/cesr_out_if.sv =====
// Report channel: valid/ready handshake carrying counts, total and shares.
interface cesr_out_if;
  logic                             valid;
  logic                             ready;
  logic [cesr_pkg::FieldWidth-1:0]  count_ch0;
  logic [cesr_pkg::FieldWidth-1:0]  count_ch1;
  logic [cesr_pkg::FieldWidth-1:0]  count_ch2;
  logic [cesr_pkg::FieldWidth-1:0]  count_ch3;
  logic [cesr_pkg::FieldWidth-1:0]  count_ch4;
  logic [cesr_pkg::FieldWidth-1:0]  total_events;
  logic [cesr_pkg::ShareWidth-1:0]  share_ch0;
  logic [cesr_pkg::ShareWidth-1:0]  share_ch1;
  logic [cesr_pkg::ShareWidth-1:0]  share_ch2;
  logic [cesr_pkg::ShareWidth-1:0]  share_ch3;
  logic [cesr_pkg::ShareWidth-1:0]  share_ch4;
  logic                             last_report;

  modport source (
    output valid, input ready,
    output count_ch0, output count_ch1, output count_ch2, output count_ch3, output count_ch4,
    output total_events,
    output share_ch0, output share_ch1, output share_ch2, output share_ch3, output share_ch4,
    output last_report
  );
  modport sink (
    input valid, output ready,
    input count_ch0, input count_ch1, input count_ch2, input count_ch3, input count_ch4,
    input total_events,
    input share_ch0, input share_ch1, input share_ch2, input share_ch3, input share_ch4,
    input last_report
  );
endinterface

// ===== src/channel_event_share_reporter_unit.sv =====
// Channel event share reporter: edge counting, bit-serial share division, report output.
//
// Usage:
//   in_ch  : one transfer per sample of the five channel levels.
//   out_ch : zero to five report transfers per sample; last_report marks the final one.
//   cfg_*  : write of the report threshold (Q1.16), only while the block is idle.
// Timing:
//   Each rising edge costs a scan step, five shares (load, 17 restoring divider
//   steps at one quotient bit per cycle, compare) and a report step, in which a
//   held report goes out first when a new one is due. The divider is shared by
//   all five shares; one sample is worked at a time.
//   A report is held back so its last_report flag is known; it goes out
//   when the next report of the sample appears or when the scan ends.
// Reset (rst_n low, synchronous): counts, total, previous levels and reported
//   shares clear, the threshold returns to 3277, the output goes invalid.
// Stall: the output register holds its transfer while out_ch.ready is low; the
//   block takes the next sample meanwhile and waits only when it has a new
//   report to load.
module channel_event_share_reporter_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  cesr_in_if.sink                         in_ch,
  cesr_out_if.source                      out_ch,
  input  logic                            cfg_wr_en,
  input  logic [cesr_pkg::ShareWidth-1:0] cfg_wr_data
);

  // control and architectural state
  cesr_pkg::state_t                 state_r, state_nxt;
  cesr_pkg::share_t                 thresh_r, thresh_nxt;
  logic [cesr_pkg::Channels-1:0]    prev_r, prev_nxt;
  logic [cesr_pkg::Channels-1:0]    edge_r, edge_nxt;
  logic [cesr_pkg::ChCntWidth-1:0]  ch_r, ch_nxt;
  logic [cesr_pkg::ChIdxWidth-1:0]  sh_r, sh_nxt;
  logic [cesr_pkg::StepWidth-1:0]   step_r, step_nxt;
  cesr_pkg::count_t                 counts_r [cesr_pkg::Channels];
  cesr_pkg::count_t                 counts_nxt [cesr_pkg::Channels];
  cesr_pkg::count_t                 total_r, total_nxt;
  cesr_pkg::share_t                 reported_r [cesr_pkg::Channels];
  cesr_pkg::share_t                 reported_nxt [cesr_pkg::Channels];
  logic                             moved_r, moved_nxt;
  logic                             pend_r, pend_nxt;
  logic                             out_valid_r, out_valid_nxt;

  // datapath (no reset)
  cesr_pkg::share_t                 shares_r [cesr_pkg::Channels];
  cesr_pkg::share_t                 shares_nxt [cesr_pkg::Channels];
  cesr_pkg::count_t                 rem_r, rem_nxt;
  cesr_pkg::share_t                 dvd_r, dvd_nxt;
  cesr_pkg::share_t                 quo_r, quo_nxt;
  cesr_pkg::field_t                 out_count_r [cesr_pkg::Channels];
  cesr_pkg::field_t                 out_count_nxt [cesr_pkg::Channels];
  cesr_pkg::field_t                 out_total_r, out_total_nxt;
  cesr_pkg::share_t                 out_share_r [cesr_pkg::Channels];
  cesr_pkg::share_t                 out_share_nxt [cesr_pkg::Channels];
  logic                             out_last_r, out_last_nxt;

  // combinational helpers
  logic [cesr_pkg::ChIdxWidth-1:0]  rd_idx;
  cesr_pkg::count_t                 cnt_rd;
  logic [cesr_pkg::CountWidth:0]    trial;
  logic [cesr_pkg::CountWidth:0]    total_ext;
  logic                             fits;
  cesr_pkg::share_t                 rep_rd;
  cesr_pkg::share_t                 diff;

  assign in_ch.ready = (state_r == cesr_pkg::ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    thresh_nxt    = cfg_wr_en ? cfg_wr_data : thresh_r;
    prev_nxt      = prev_r;
    edge_nxt      = edge_r;
    ch_nxt        = ch_r;
    sh_nxt        = sh_r;
    step_nxt      = step_r;
    counts_nxt    = counts_r;
    total_nxt     = total_r;
    reported_nxt  = reported_r;
    moved_nxt     = moved_r;
    pend_nxt      = pend_r;
    shares_nxt    = shares_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    quo_nxt       = quo_r;
    out_count_nxt = out_count_r;
    out_total_nxt = out_total_r;
    out_share_nxt = out_share_r;
    out_last_nxt  = out_last_r;
    // an accepted report frees the output register
    out_valid_nxt = out_valid_r & ~out_ch.ready;

    // one count read port: the scan uses the channel index, the divider the share index
    rd_idx    = (state_r == cesr_pkg::ST_SCAN) ? ch_r[cesr_pkg::ChIdxWidth-1:0] : sh_r;
    cnt_rd    = counts_r[rd_idx];
    rep_rd    = reported_r[sh_r];
    total_ext = {1'b0, total_r};
    trial     = {rem_r, dvd_r[cesr_pkg::ShareWidth-1]};
    fits      = (trial >= total_ext);
    diff      = (quo_r > rep_rd) ? (quo_r - rep_rd) : (rep_rd - quo_r);

    unique case (state_r)
      cesr_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          edge_nxt  = in_ch.channel_levels[cesr_pkg::Channels-1:0] & ~prev_r;
          prev_nxt  = in_ch.channel_levels[cesr_pkg::Channels-1:0];
          ch_nxt    = '0;
          state_nxt = cesr_pkg::ST_SCAN;
        end
      end
      cesr_pkg::ST_SCAN: begin
        if (ch_r == cesr_pkg::ChCntWidth'(cesr_pkg::Channels)) begin
          state_nxt = cesr_pkg::ST_FINISH;
        end else if (edge_r[rd_idx] && (total_r != cesr_pkg::CountMax)) begin
          counts_nxt[rd_idx] = cnt_rd + cesr_pkg::CountWidth'(1);
          total_nxt          = total_r + cesr_pkg::CountWidth'(1);
          sh_nxt             = '0;
          moved_nxt          = 1'b0;
          state_nxt          = cesr_pkg::ST_DIV_INIT;
        end else begin
          ch_nxt = ch_r + cesr_pkg::ChCntWidth'(1);
        end
      end
      cesr_pkg::ST_DIV_INIT: begin
        // count * 2^16: upper part preloads the remainder, low bits shift in
        rem_nxt   = cnt_rd >> 1;
        dvd_nxt   = {cnt_rd[0], cesr_pkg::FracBits'(0)};
        quo_nxt   = '0;
        step_nxt  = '0;
        state_nxt = cesr_pkg::ST_DIV_STEP;
      end
      cesr_pkg::ST_DIV_STEP: begin
        if (fits) begin
          rem_nxt = cesr_pkg::CountWidth'(trial - total_ext);
        end else begin
          rem_nxt = cesr_pkg::CountWidth'(trial);
        end
        quo_nxt  = {quo_r[cesr_pkg::ShareWidth-2:0], fits};
        dvd_nxt  = dvd_r << 1;
        step_nxt = step_r + cesr_pkg::StepWidth'(1);
        if (step_r == cesr_pkg::StepWidth'(cesr_pkg::ShareWidth - 1)) begin
          state_nxt = cesr_pkg::ST_COMPARE;
        end
      end
      cesr_pkg::ST_COMPARE: begin
        shares_nxt[sh_r] = quo_r;
        if (diff > thresh_r) begin
          moved_nxt = 1'b1;
        end
        if (sh_r == cesr_pkg::ChIdxWidth'(cesr_pkg::Channels - 1)) begin
          state_nxt = cesr_pkg::ST_REPORT;
        end else begin
          sh_nxt    = sh_r + cesr_pkg::ChIdxWidth'(1);
          state_nxt = cesr_pkg::ST_DIV_INIT;
        end
      end
      cesr_pkg::ST_REPORT: begin
        if (!moved_r) begin
          ch_nxt    = ch_r + cesr_pkg::ChCntWidth'(1);
          state_nxt = cesr_pkg::ST_SCAN;
        end else if (pend_r) begin
          // a later report exists, so the held one is not the last
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b0;
          pend_nxt      = 1'b0;
        end else if (!out_valid_r || out_ch.ready) begin
          for (int i = 0; i < cesr_pkg::Channels; i++) begin
            out_count_nxt[i] = cesr_pkg::FieldWidth'(counts_r[i]);
            out_share_nxt[i] = shares_r[i];
            reported_nxt[i]  = shares_r[i];
          end
          out_total_nxt = cesr_pkg::FieldWidth'(total_r);
          pend_nxt      = 1'b1;
          ch_nxt        = ch_r + cesr_pkg::ChCntWidth'(1);
          state_nxt     = cesr_pkg::ST_SCAN;
        end
      end
      cesr_pkg::ST_FINISH: begin
        if (pend_r) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          pend_nxt      = 1'b0;
        end
        state_nxt = cesr_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = cesr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cesr_pkg::ST_IDLE;
      thresh_r    <= cesr_pkg::ThresholdReset;
      prev_r      <= '0;
      edge_r      <= '0;
      ch_r        <= '0;
      sh_r        <= '0;
      step_r      <= '0;
      total_r     <= '0;
      moved_r     <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < cesr_pkg::Channels; i++) begin
        counts_r[i]   <= '0;
        reported_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      thresh_r    <= thresh_nxt;
      prev_r      <= prev_nxt;
      edge_r      <= edge_nxt;
      ch_r        <= ch_nxt;
      sh_r        <= sh_nxt;
      step_r      <= step_nxt;
      total_r     <= total_nxt;
      moved_r     <= moved_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      counts_r    <= counts_nxt;
      reported_r  <= reported_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shares_r    <= shares_nxt;
    rem_r       <= rem_nxt;
    dvd_r       <= dvd_nxt;
    quo_r       <= quo_nxt;
    out_count_r <= out_count_nxt;
    out_total_r <= out_total_nxt;
    out_share_r <= out_share_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.count_ch0    = out_count_r[0];
  assign out_ch.count_ch1    = out_count_r[1];
  assign out_ch.count_ch2    = out_count_r[2];
  assign out_ch.count_ch3    = out_count_r[3];
  assign out_ch.count_ch4    = out_count_r[4];
  assign out_ch.total_events = out_total_r;
  assign out_ch.share_ch0    = out_share_r[0];
  assign out_ch.share_ch1    = out_share_r[1];
  assign out_ch.share_ch2    = out_share_r[2];
  assign out_ch.share_ch3    = out_share_r[3];
  assign out_ch.share_ch4    = out_share_r[4];
  assign out_ch.last_report  = out_last_r;

endmodule

// ===== bench/channel_event_share_reporter_unit_tb.sv =====
// Testbench for the channel event share reporter: predicted reports checked against the output.
module channel_event_share_reporter_unit_tb;

  // Run limit. About 200 samples, plus stalls, the long hold-off and settling,
  // stay far below this.
  localparam int LimitCycles = 1_000_000;
  // Wait longer than a sample with all five channels rising takes before
  // touching the threshold or ending the run.
  localparam int SettleCycles = 600;
  // Long receiver hold-off, long enough for the block to back up into its input.
  localparam int HoldCycles = 3000;

  localparam logic [cesr_pkg::LevelWidth-1:0] AllLow  = '0;
  localparam logic [cesr_pkg::LevelWidth-1:0] AllHigh = '1;

  localparam cesr_pkg::share_t ThresholdMax = cesr_pkg::share_t'(1 << cesr_pkg::FracBits);

  // One report as seen on the output channel.
  typedef struct packed {
    cesr_pkg::field_t [cesr_pkg::Channels-1:0] count;
    cesr_pkg::field_t                          total;
    cesr_pkg::share_t [cesr_pkg::Channels-1:0] share;
    logic                                      last_mark;
  } share_report_t;

  // Scoreboard: tracks the block's counting state, predicts reports for each
  // accepted sample and checks each report transfer against the oldest one.
  class share_scoreboard;
    cesr_pkg::share_t                 threshold;
    logic [cesr_pkg::LevelWidth-1:0]  prev_levels;
    cesr_pkg::count_t                 counts [cesr_pkg::Channels];
    cesr_pkg::count_t                 total;
    cesr_pkg::share_t                 reported [cesr_pkg::Channels];
    share_report_t                    pending_reports [$];
    int                               errors;

    function new();
      threshold   = cesr_pkg::ThresholdReset;
      prev_levels = '0;
      total       = '0;
      errors      = 0;
      for (int j = 0; j < cesr_pkg::Channels; j++) begin
        counts[j]   = '0;
        reported[j] = '0;
      end
    endfunction

    // Walk the channels in order; every counted edge recomputes all shares
    // and reports if any share moved by more than the threshold.
    function void note_sample(input logic [cesr_pkg::LevelWidth-1:0] levels);
      share_report_t    sample_reports [$];
      share_report_t    rep;
      cesr_pkg::share_t fresh [cesr_pkg::Channels];
      cesr_pkg::share_t gap;
      logic [31:0]      num;
      bit               moved;
      for (int c = 0; c < cesr_pkg::Channels; c++) begin
        if (levels[c] && !prev_levels[c] && total != cesr_pkg::CountMax) begin
          counts[c] = counts[c] + 1'b1;
          total     = total + 1'b1;
          moved     = 1'b0;
          for (int j = 0; j < cesr_pkg::Channels; j++) begin
            num      = 32'(counts[j]) << cesr_pkg::FracBits;
            fresh[j] = cesr_pkg::share_t'(num / 32'(total));
            gap      = (fresh[j] > reported[j]) ? fresh[j] - reported[j]
                                                : reported[j] - fresh[j];
            if (gap > threshold) moved = 1'b1;
          end
          if (moved) begin
            for (int j = 0; j < cesr_pkg::Channels; j++) begin
              rep.count[j] = cesr_pkg::field_t'(counts[j]);
              rep.share[j] = fresh[j];
              reported[j]  = fresh[j];
            end
            rep.total     = cesr_pkg::field_t'(total);
            rep.last_mark = 1'b0;
            sample_reports.push_back(rep);
          end
        end
        prev_levels[c] = levels[c];
      end
      if (sample_reports.size() > 0)
        sample_reports[sample_reports.size() - 1].last_mark = 1'b1;
      foreach (sample_reports[i]) pending_reports.push_back(sample_reports[i]);
    endfunction

    function void check_report(input share_report_t got);
      share_report_t want;
      if (pending_reports.size() == 0) begin
        $error("report transfer with no report expected (total %0d)", got.total);
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      for (int j = 0; j < cesr_pkg::Channels; j++) begin
        if (got.count[j] !== want.count[j]) begin
          $error("count_ch%0d: expected %0d, actual %0d", j, want.count[j], got.count[j]);
          errors++;
        end
        if (got.share[j] !== want.share[j]) begin
          $error("share_ch%0d: expected %0d, actual %0d", j, want.share[j], got.share[j]);
          errors++;
        end
      end
      if (got.total !== want.total) begin
        $error("total_events: expected %0d, actual %0d", want.total, got.total);
        errors++;
      end
      if (got.last_mark !== want.last_mark) begin
        $error("last_report: expected %0b, actual %0b", want.last_mark, got.last_mark);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_wr_en;
  cesr_pkg::share_t cfg_wr_data;

  cesr_in_if  in_bus ();
  cesr_out_if out_bus ();

  channel_event_share_reporter_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_bus),
    .out_ch      (out_bus),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  share_scoreboard board = new();

  // Random idle bursts on both sides while set; cleared for the closing part.
  bit gaps_enabled = 1'b1;
  // Main sequence raises this to make the receiver hold off for HoldCycles.
  bit hold_off_req = 1'b0;
  int cycles = 0;

  always #5 clk = ~clk;

  // Watchdog: a stuck handshake or a missing report ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LimitCycles) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic share_report_t capture_report();
    share_report_t r;
    r.count[0]  = out_bus.count_ch0;
    r.count[1]  = out_bus.count_ch1;
    r.count[2]  = out_bus.count_ch2;
    r.count[3]  = out_bus.count_ch3;
    r.count[4]  = out_bus.count_ch4;
    r.total     = out_bus.total_events;
    r.share[0]  = out_bus.share_ch0;
    r.share[1]  = out_bus.share_ch1;
    r.share[2]  = out_bus.share_ch2;
    r.share[3]  = out_bus.share_ch3;
    r.share[4]  = out_bus.share_ch4;
    r.last_mark = out_bus.last_report;
    return r;
  endfunction

  // Report side: alternates ready stretches and stall bursts, and honors a
  // long hold-off request. Transfers are seen at the edge where valid and
  // ready were both high, so sampled values are the ones before the edge.
  initial begin : report_sink
    int span;
    out_bus.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (gaps_enabled && $urandom_range(0, 3) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_bus.ready <= 1'b1;
        span = gaps_enabled ? $urandom_range(1, 24) : 1;
        repeat (span) begin
          @(posedge clk);
          if (out_bus.valid && out_bus.ready) board.check_report(capture_report());
        end
      end
    end
  end

  // Offer one sample, with an optional idle burst first. Valid stays high
  // across back-to-back transfers; it only drops for a gap.
  task automatic offer_levels(input logic [cesr_pkg::LevelWidth-1:0] levels);
    int gap;
    gap = (gaps_enabled && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid          <= 1'b1;
    in_bus.channel_levels <= levels;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    board.note_sample(levels);
  endtask

  // Block is idle once every predicted report is out and a sample that
  // reported nothing has had time to finish its divisions.
  task automatic settle_block();
    in_bus.valid <= 1'b0;
    while (board.pending_reports.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_threshold(input cesr_pkg::share_t value);
    settle_block();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    board.threshold = value;
  endtask

  // Mostly random levels, with all-low samples to re-arm edges and all-high
  // samples to raise all five channels at once.
  function automatic logic [cesr_pkg::LevelWidth-1:0] pick_levels();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return cesr_pkg::LevelWidth'($urandom_range(0, 31));
    if (r < 8) return AllLow;
    return AllHigh;
  endfunction

  task automatic random_phase(input cesr_pkg::share_t value, input int n);
    write_threshold(value);
    repeat (n) offer_levels(pick_levels());
  endtask

  initial begin : main_sequence
    logic [cesr_pkg::LevelWidth-1:0] directed [$];
    in_bus.valid          <= 1'b0;
    in_bus.channel_levels <= '0;
    cfg_wr_en             <= 1'b0;
    cfg_wr_data           <= '0;
    rst_n                 <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset threshold: no rise, all five channels rising in one
    // sample (later edges compare against shares reported earlier in the
    // sample), levels held high, single channels, mixed patterns.
    directed = '{5'h00, 5'h1F, 5'h1F, 5'h00, 5'h01, 5'h03, 5'h00, 5'h10,
                 5'h0A, 5'h15, 5'h00, 5'h1F, 5'h00};
    foreach (directed[i]) offer_levels(directed[i]);

    // Zero threshold: any share change reports.
    write_threshold('0);
    directed = '{5'h01, 5'h00, 5'h01, 5'h00, 5'h02};
    foreach (directed[i]) offer_levels(directed[i]);

    // Threshold at one full share can never be exceeded.
    write_threshold(ThresholdMax);
    directed = '{5'h1F, 5'h00, 5'h1F};
    foreach (directed[i]) offer_levels(directed[i]);

    // Random part over a spread of thresholds, extremes included.
    random_phase('0, 20);

    // Receiver holds off while edges keep coming: the output register and
    // the divider back up until the input stalls.
    hold_off_req = 1'b1;
    repeat (6) begin
      offer_levels(AllLow);
      offer_levels(AllHigh);
    end

    random_phase(cesr_pkg::share_t'(1), 20);
    random_phase(ThresholdMax, 20);
    random_phase(cesr_pkg::ThresholdReset, 20);
    random_phase(cesr_pkg::share_t'($urandom_range(0, 4000)), 20);
    random_phase(cesr_pkg::share_t'($urandom_range(0, 65536)), 20);
    random_phase(ThresholdMax - 1'b1, 20);

    // Closing part runs without idle bursts.
    gaps_enabled = 1'b0;
    random_phase(cesr_pkg::share_t'($urandom_range(0, 2000)), 20);
    directed = '{5'h00, 5'h1F, 5'h00, 5'h15, 5'h0A, 5'h00, 5'h1F};
    foreach (directed[i]) offer_levels(directed[i]);

    settle_block();
    if (board.errors == 0 && board.pending_reports.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
